// ===== hdl/day_serial_to_date_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the serial day to date converter.
// Each macro checks an implication on the rising edge of clk, off during rst.
// ----------------------------------------------------------------------------
`ifndef DAY_SERIAL_TO_DATE_ASSERT_SVH
`define DAY_SERIAL_TO_DATE_ASSERT_SVH

`ifndef SYNTHESIS

`define DSD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("day_serial_to_date: same-cycle check failed");

`define DSD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("day_serial_to_date: next-cycle check failed");

`else

`define DSD_ASSERT_NOW(label, ante, cons)

`define DSD_ASSERT_NXT(label, ante, cons)

`endif

`endif

// ===== hdl/dsd_pkg.sv =====
// ----------------------------------------------------------------------------
// dsd_pkg
// Widths, calendar constants and the month-length table of the converter.
// ----------------------------------------------------------------------------
package dsd_pkg;

  localparam int SerialW = 22;
  localparam int DayW    = 5;
  localparam int MonthW  = 4;
  localparam int YearW   = 14;
  localparam int DaysW   = 23;

  localparam logic [YearW-1:0] CycleYear       = 14'd1600;
  localparam logic [DaysW-1:0] DaysCycleToBase = 23'd109573;
  localparam logic [DaysW-1:0] DaysPer400      = 23'd146097;
  localparam logic [DaysW-1:0] DaysLeapCent    = 23'd36525;
  localparam logic [DaysW-1:0] DaysCommonCent  = 23'd36524;
  localparam logic [DaysW-1:0] DaysLeapQuad    = 23'd1461;
  localparam logic [DaysW-1:0] DaysCommonQuad  = 23'd1460;
  localparam logic [DaysW-1:0] DaysLeapYear    = 23'd366;
  localparam logic [DaysW-1:0] DaysCommonYear  = 23'd365;

  localparam logic [MonthW-1:0] MonJan = 4'd0;
  localparam logic [MonthW-1:0] MonFeb = 4'd1;
  localparam logic [MonthW-1:0] MonApr = 4'd3;
  localparam logic [MonthW-1:0] MonJun = 4'd5;
  localparam logic [MonthW-1:0] MonSep = 4'd8;
  localparam logic [MonthW-1:0] MonNov = 4'd10;
  localparam logic [MonthW-1:0] MonDec = 4'd11;

  function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] m,
                                                 input logic leap);
    logic [DayW-1:0] len;
    case (m)
      MonFeb:                         len = leap ? 5'd29 : 5'd28;
      MonApr, MonJun, MonSep, MonNov: len = 5'd30;
      default:                        len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== hdl/day_serial_to_date.sv =====
// One shared compare-subtract unit strips 400-year cycles, centuries, four-year spans,
// years and months in turn; serial_stall holds off a new beat until the sequencer is idle.
// A finished result waits in the output register while the next beat is taken.
// Reset (rst, synchronous, active high) returns the sequencer to idle and
// drops date_valid.
// ----------------------------------------------------------------------------
// day_serial_to_date
// Converts a serial day number (1 is 1 January 1900) to a Gregorian date.
// ----------------------------------------------------------------------------
`include "day_serial_to_date_assert.svh"

module day_serial_to_date (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          serial_valid,
  output logic                          serial_stall,
  input  logic [dsd_pkg::SerialW-1:0]   serial_number,
  output logic                          date_valid,
  input  logic                          date_stall,
  output logic [dsd_pkg::DayW-1:0]      day_of_month,
  output logic [dsd_pkg::MonthW-1:0]    month_number,
  output logic [dsd_pkg::YearW-1:0]     year_number
);
  import dsd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CYCLE,
    S_CENT,
    S_QFIRST,
    S_QUAD,
    S_YEAR,
    S_MONTH
  } state_t;

  state_t             state;
  logic [DaysW-1:0]   days;
  logic [YearW-1:0]   year;
  logic [MonthW-1:0]  month;
  logic [2:0]         step;
  logic               cent_first;
  logic               leap;

  logic [DaysW-1:0]   sub_op;
  logic [YearW-1:0]   year_inc;
  logic [DaysW:0]     diff;
  logic               ge;
  logic [DaysW-1:0]   start_days;
  logic               out_free;
  logic               done;

  always_comb begin
    sub_op   = DaysCommonYear;
    year_inc = 14'd1;
    case (state)
      S_CYCLE: begin
        sub_op   = DaysPer400 << step;
        year_inc = 14'd400 << step;
      end
      S_CENT: begin
        sub_op   = cent_first ? DaysLeapCent : DaysCommonCent;
        year_inc = 14'd100;
      end
      S_QFIRST: begin
        sub_op   = DaysCommonQuad;
        year_inc = 14'd4;
      end
      S_QUAD: begin
        sub_op   = DaysLeapQuad << step;
        year_inc = 14'd4 << step;
      end
      S_YEAR: begin
        sub_op   = leap ? DaysLeapYear : DaysCommonYear;
        year_inc = 14'd1;
      end
      S_MONTH: begin
        sub_op   = {{(DaysW-DayW){1'b0}}, month_days(month, leap)};
        year_inc = 14'd0;
      end
      default: begin
        sub_op   = DaysCommonYear;
        year_inc = 14'd0;
      end
    endcase
  end

  assign diff       = {1'b0, days} - {1'b0, sub_op};
  assign ge         = !diff[DaysW];
  assign start_days = ((serial_number == '0) ? DaysW'(0)
                                             : DaysW'(serial_number - 1'b1))
                      + DaysCycleToBase;
  assign out_free     = !date_valid || !date_stall;
  assign done         = (state == S_MONTH) && !(ge && month != MonDec) && out_free;
  assign serial_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      date_valid <= 1'b0;
    end else begin
      if (done) begin
        date_valid <= 1'b1;
      end else if (date_valid && !date_stall) begin
        date_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (serial_valid) begin
            days  <= start_days;
            year  <= CycleYear;
            step  <= 3'd4;
            state <= S_CYCLE;
          end
        end
        S_CYCLE: begin
          if (ge) begin
            days <= diff[DaysW-1:0];
            year <= year + year_inc;
          end
          if (step == 3'd0) begin
            cent_first <= 1'b1;
            state      <= S_CENT;
          end else begin
            step <= step - 3'd1;
          end
        end
        S_CENT: begin
          if (ge) begin
            days       <= diff[DaysW-1:0];
            year       <= year + year_inc;
            cent_first <= 1'b0;
          end else if (cent_first) begin
            step  <= 3'd4;
            leap  <= 1'b1;
            state <= S_QUAD;
          end else begin
            state <= S_QFIRST;
          end
        end
        S_QFIRST: begin
          if (ge) begin
            days  <= diff[DaysW-1:0];
            year  <= year + year_inc;
            step  <= 3'd4;
            leap  <= 1'b1;
            state <= S_QUAD;
          end else begin
            leap  <= 1'b0;
            state <= S_YEAR;
          end
        end
        S_QUAD: begin
          if (ge) begin
            days <= diff[DaysW-1:0];
            year <= year + year_inc;
          end
          if (step == 3'd0) begin
            state <= S_YEAR;
          end else begin
            step <= step - 3'd1;
          end
        end
        S_YEAR: begin
          if (ge) begin
            days <= diff[DaysW-1:0];
            year <= year + year_inc;
            leap <= 1'b0;
          end else begin
            month <= MonJan;
            state <= S_MONTH;
          end
        end
        S_MONTH: begin
          if (ge && month != MonDec) begin
            days  <= diff[DaysW-1:0];
            month <= month + 4'd1;
          end else if (out_free) begin
            day_of_month <= days[DayW-1:0] + 5'd1;
            month_number <= month + 4'd1;
            year_number  <= year;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `DSD_ASSERT_NXT(a_accept_busy, serial_valid && !serial_stall, serial_stall)
  `DSD_ASSERT_NOW(a_out_range, date_valid, day_of_month != '0 && month_number - 4'd1 < 4'd12)
  `DSD_ASSERT_NOW(a_cent_bound, state == S_CENT, days < DaysPer400)
  `DSD_ASSERT_NOW(a_year_bound, state == S_YEAR, days < DaysLeapQuad)
  `DSD_ASSERT_NOW(a_month_bound, state == S_MONTH, month <= MonDec && days < DaysLeapYear)

endmodule
